### rtl/tas_pkg.sv
// shared types, widths, constants and the arctangent table of the tilt angle block
package tas_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int PERIOD_W  = 17;
    localparam int LIMIT_W   = 16;
    localparam int TILT_W    = 16;
    localparam int LEVEL_W   = 16;

    // square root: radicand (x*x + y*y) * 2^16 and the bit-per-cell root
    localparam int SQ_W      = 48;
    localparam int ROOT_W    = 24;

    // cordic datapath and angle accumulator (degrees, 16 fraction bits)
    localparam int XY_W      = 27;
    localparam int ACC_W     = 26;
    localparam int ACC_FRAC  = 16;
    localparam int TABLE_LEN = 24;

    // level division: 3600 * 2^f = 2^(f+4) * 225, the odd part by reciprocal
    localparam int DIV_ODD     = 225;
    localparam int RECIP_SHIFT = 30;
    localparam int RECIP_W     = 23;
    localparam int RECIP       = 4772185;
    localparam int Q1_W        = 22;

    localparam logic [PERIOD_W-1:0] PWM_PERIOD_RESET  = 17'd25000;
    localparam logic [LIMIT_W-1:0]  ANGLE_LIMIT_RESET = 16'd23040;

    typedef logic [0:0] cfg_addr_t;
    localparam cfg_addr_t CFG_PWM_PERIOD  = 1'b0;
    localparam cfg_addr_t CFG_ANGLE_LIMIT = 1'b1;

    typedef struct packed {
        logic [SQ_W-1:0]            rem;
        logic [SQ_W-1:0]            root;
        logic signed [SAMPLE_W-1:0] z;
        logic                       invalid;
    } sqrt_t;

    typedef struct packed {
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [ACC_W-1:0] acc;
        logic                    invalid;
    } cordic_t;

    typedef struct packed {
        logic [TILT_W-1:0]  tilt;
        logic [LEVEL_W-1:0] level;
        logic               over;
        logic               invalid;
    } result_t;

    // atan(2^-i) in degrees times 2^16, rounded to nearest
    function automatic logic signed [ACC_W-1:0] atan_q16(input int idx);
        logic signed [ACC_W-1:0] val;
        unique case (idx)
            0:       val = 26'sd2949120;
            1:       val = 26'sd1740967;
            2:       val = 26'sd919879;
            3:       val = 26'sd466945;
            4:       val = 26'sd234379;
            5:       val = 26'sd117304;
            6:       val = 26'sd58666;
            7:       val = 26'sd29335;
            8:       val = 26'sd14668;
            9:       val = 26'sd7334;
            10:      val = 26'sd3667;
            11:      val = 26'sd1833;
            12:      val = 26'sd917;
            13:      val = 26'sd458;
            14:      val = 26'sd229;
            15:      val = 26'sd115;
            16:      val = 26'sd57;
            17:      val = 26'sd29;
            18:      val = 26'sd14;
            19:      val = 26'sd7;
            20:      val = 26'sd4;
            21:      val = 26'sd2;
            22:      val = 26'sd1;
            default: val = 26'sd0;
        endcase
        return val;
    endfunction

endpackage

### rtl/tas_sqrt_cell.sv
// one cell of the square root chain: settles one root bit per cycle while en is high
module tas_sqrt_cell #(
    parameter int STAGE = 0
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  tas_pkg::sqrt_t in_data,
    output logic           out_valid,
    output tas_pkg::sqrt_t out_data
);

    localparam int W = tas_pkg::SQ_W;
    localparam logic [W-1:0] BIT_VAL = W'(1) << (2 * (tas_pkg::ROOT_W - 1 - STAGE));

    logic           valid_reg;
    tas_pkg::sqrt_t data_reg;
    tas_pkg::sqrt_t data_next;
    logic [W-1:0]   trial;

    always_comb begin
        trial     = in_data.root + BIT_VAL;
        data_next = in_data;
        if (in_data.rem >= trial) begin
            data_next.rem  = in_data.rem - trial;
            data_next.root = (in_data.root >> 1) + BIT_VAL;
        end else begin
            data_next.root = in_data.root >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/tas_cordic_cell.sv
// one vectoring cordic micro-rotation with its fixed shift and table angle
module tas_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  tas_pkg::cordic_t in_data,
    output logic             out_valid,
    output tas_pkg::cordic_t out_data
);

    localparam logic signed [tas_pkg::ACC_W-1:0] ANGLE = tas_pkg::atan_q16(STAGE);

    logic                            valid_reg;
    tas_pkg::cordic_t                data_reg;
    tas_pkg::cordic_t                data_next;
    logic signed [tas_pkg::XY_W-1:0] dx;
    logic signed [tas_pkg::XY_W-1:0] dy;

    always_comb begin
        dx        = in_data.y >>> STAGE;
        dy        = in_data.x >>> STAGE;
        data_next = in_data;
        // rotate towards the x axis, y sign picks the direction
        if (!in_data.y[tas_pkg::XY_W-1]) begin
            data_next.x   = in_data.x + dx;
            data_next.y   = in_data.y - dy;
            data_next.acc = in_data.acc + ANGLE;
        end else begin
            data_next.x   = in_data.x - dx;
            data_next.y   = in_data.y + dy;
            data_next.acc = in_data.acc - ANGLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/tas_servo.sv
// angle clamp and rounding, limit flag and pwm compare level over five stages
module tas_servo #(
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  tas_pkg::cordic_t                 in_data,
    input  logic [tas_pkg::PERIOD_W-1:0]     pwm_period,
    input  logic [tas_pkg::LIMIT_W-1:0]      angle_limit,
    output logic                             out_valid,
    output tas_pkg::result_t                 out_data
);

    localparam int ACC_W    = tas_pkg::ACC_W;
    localparam int TILT_W   = tas_pkg::TILT_W;
    localparam int Q1_W     = tas_pkg::Q1_W;
    localparam int CLAMP_W  = 24;
    localparam int RND_W    = CLAMP_W + 1;
    localparam int SH       = tas_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int FULL     = 180 << ANGLE_FRAC_BITS;
    localparam int TILT_MAX = (FULL > 65535) ? 65535 : FULL;
    localparam int SUM_W    = $clog2(FULL + TILT_MAX + 1);
    localparam int PROD_W   = tas_pkg::PERIOD_W + SUM_W;
    localparam int DIV_SH   = ANGLE_FRAC_BITS + 4;
    localparam int SCL_W    = Q1_W + tas_pkg::RECIP_W;

    localparam logic signed [ACC_W-1:0] ACC_TOP = ACC_W'(180 << tas_pkg::ACC_FRAC);
    localparam logic [RND_W-1:0]        HALF    = RND_W'(1) << (SH - 1);

    // stage 1: clamped and rounded tilt
    logic              s1_valid_reg;
    logic [TILT_W-1:0] s1_tilt_reg, s1_tilt_next;
    logic              s1_invalid_reg;
    logic [CLAMP_W-1:0] acc_c;
    logic [RND_W-1:0]   rnd;

    always_comb begin
        if (in_data.acc[ACC_W-1]) begin
            acc_c = '0;
        end else if (in_data.acc > ACC_TOP) begin
            acc_c = CLAMP_W'(ACC_TOP);
        end else begin
            acc_c = in_data.acc[CLAMP_W-1:0];
        end
        rnd = ({1'b0, acc_c} + HALF) >> SH;
        if (rnd > RND_W'(FULL)) begin
            rnd = RND_W'(FULL);
        end
        if (rnd > RND_W'(TILT_MAX)) begin
            rnd = RND_W'(TILT_MAX);
        end
        s1_tilt_next = in_data.invalid ? '0 : rnd[TILT_W-1:0];
    end

    // stage 2: limit flag and (180 + angle) in output lsbs
    logic              s2_valid_reg;
    logic [TILT_W-1:0] s2_tilt_reg;
    logic [SUM_W-1:0]  s2_sum_reg;
    logic              s2_over_reg;
    logic              s2_invalid_reg;

    // stage 3: period times the sum
    logic              s3_valid_reg;
    logic [TILT_W-1:0] s3_tilt_reg;
    logic [PROD_W-1:0] s3_prod_reg;
    logic              s3_over_reg;
    logic              s3_invalid_reg;

    // stage 4: power of two part of the divisor dropped, reciprocal of 225 applied
    logic              s4_valid_reg;
    logic [TILT_W-1:0] s4_tilt_reg;
    logic [Q1_W-1:0]   s4_q1_reg;
    logic [SCL_W-1:0]  s4_scaled_reg;
    logic              s4_over_reg;
    logic              s4_invalid_reg;
    logic [Q1_W-1:0]   q1;

    assign q1 = Q1_W'(s3_prod_reg >> DIV_SH);

    // stage 5: quotient estimate is low by at most one
    logic              s5_valid_reg;
    tas_pkg::result_t  s5_reg, s5_next;
    logic [Q1_W-1:0]   est;
    logic [Q1_W-1:0]   chk;

    always_comb begin
        est = Q1_W'(s4_scaled_reg >> tas_pkg::RECIP_SHIFT);
        chk = s4_q1_reg - Q1_W'(est * Q1_W'(tas_pkg::DIV_ODD));
        if (chk >= Q1_W'(tas_pkg::DIV_ODD)) begin
            est = est + Q1_W'(1);
        end
        s5_next.tilt    = s4_tilt_reg;
        s5_next.level   = est[tas_pkg::LEVEL_W-1:0];
        s5_next.over    = s4_over_reg;
        s5_next.invalid = s4_invalid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_tilt_reg    <= s1_tilt_next;
            s1_invalid_reg <= in_data.invalid;

            s2_tilt_reg    <= s1_tilt_reg;
            s2_sum_reg     <= SUM_W'(FULL) + SUM_W'(s1_tilt_reg);
            s2_over_reg    <= (s1_tilt_reg > angle_limit);
            s2_invalid_reg <= s1_invalid_reg;

            s3_tilt_reg    <= s2_tilt_reg;
            s3_prod_reg    <= PROD_W'(pwm_period) * PROD_W'(s2_sum_reg);
            s3_over_reg    <= s2_over_reg;
            s3_invalid_reg <= s2_invalid_reg;

            s4_tilt_reg    <= s3_tilt_reg;
            s4_q1_reg      <= q1;
            s4_scaled_reg  <= SCL_W'(q1) * SCL_W'(tas_pkg::RECIP);
            s4_over_reg    <= s3_over_reg;
            s4_invalid_reg <= s3_invalid_reg;

            s5_reg         <= s5_next;
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_data  = s5_reg;

endmodule

### rtl/tilt_angle_to_servo_level.sv
// top level: accelerometer tilt angle and servo pwm compare level
// path to m_tvalid: square, sum, square root, prep, cordic, servo and output registers
// throughput: one request per cycle when not held, set by the square root and cordic chains
// the pipeline holds only when a result waits in the output register and the last stage is full
// reset (aresetn low, synchronous) empties every stage and loads the register defaults
module tilt_angle_to_servo_level #(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // accel_x [15:0], accel_y [31:16], accel_z [47:32]
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // tilt_angle [15:0], servo_level [31:16]
    output logic [1:0]  m_tuser,   // over_limit [0], invalid_vector [1]
    // register writes
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [16:0] cfg_wdata
);

    localparam int SAMPLE_W = tas_pkg::SAMPLE_W;
    localparam int ROOT_W   = tas_pkg::ROOT_W;
    localparam int XY_W     = tas_pkg::XY_W;
    localparam int ACC_W    = tas_pkg::ACC_W;
    localparam int SQR_W    = 2 * SAMPLE_W - 1;
    localparam int SUM_W    = 2 * SAMPLE_W;
    localparam int FULL     = 180 << ANGLE_FRAC_BITS;
    localparam int TILT_MAX = (FULL > 65535) ? 65535 : FULL;

    // configuration registers
    logic [tas_pkg::PERIOD_W-1:0] pwm_period_reg;
    logic [tas_pkg::LIMIT_W-1:0]  angle_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pwm_period_reg  <= tas_pkg::PWM_PERIOD_RESET;
            angle_limit_reg <= tas_pkg::ANGLE_LIMIT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                tas_pkg::CFG_PWM_PERIOD:  pwm_period_reg  <= cfg_wdata;
                tas_pkg::CFG_ANGLE_LIMIT: angle_limit_reg <= cfg_wdata[tas_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // global advance: hold only when the last stage would overrun a waiting result
    logic             en;
    logic             res_valid;
    tas_pkg::result_t res_data;
    logic             out_valid_reg;
    tas_pkg::result_t out_reg;

    assign en       = !(res_valid && out_valid_reg && !m_tready);
    assign s_tready = en;

    // squares of x and y, z and the zero vector flag carried along
    logic signed [SAMPLE_W-1:0] ax, ay, az;
    logic signed [SUM_W-1:0]    xx, yy;
    logic                       sq_valid_reg;
    logic [SQR_W-1:0]           xx_reg, yy_reg;
    logic signed [SAMPLE_W-1:0] sq_z_reg;
    logic                       sq_invalid_reg;

    assign ax = s_tdata[15:0];
    assign ay = s_tdata[31:16];
    assign az = s_tdata[47:32];
    assign xx = ax * ax;
    assign yy = ay * ay;

    // sum of squares
    logic                       sum_valid_reg;
    logic [SUM_W-1:0]           sum_reg;
    logic signed [SAMPLE_W-1:0] sum_z_reg;
    logic                       sum_invalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
        end else if (en) begin
            sq_valid_reg  <= s_tvalid;
            sum_valid_reg <= sq_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xx_reg          <= xx[SQR_W-1:0];
            yy_reg          <= yy[SQR_W-1:0];
            sq_z_reg        <= az;
            sq_invalid_reg  <= (ax == '0) && (ay == '0) && (az == '0);
            sum_reg         <= SUM_W'(xx_reg) + SUM_W'(yy_reg);
            sum_z_reg       <= sq_z_reg;
            sum_invalid_reg <= sq_invalid_reg;
        end
    end

    // square root chain, radicand scaled by 2^16 so the root has 8 fraction bits
    tas_pkg::sqrt_t sr_data  [ROOT_W+1];
    logic           sr_valid [ROOT_W+1];

    assign sr_valid[0]         = sum_valid_reg;
    assign sr_data[0].rem      = {sum_reg, 16'b0};
    assign sr_data[0].root     = '0;
    assign sr_data[0].z        = sum_z_reg;
    assign sr_data[0].invalid  = sum_invalid_reg;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        tas_sqrt_cell #(
            .STAGE (k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (sr_valid[k]),
            .in_data   (sr_data[k]),
            .out_valid (sr_valid[k+1]),
            .out_data  (sr_data[k+1])
        );
    end

    // start vector (z*256, r); a negative z is turned by -90 degrees first
    logic signed [XY_W-1:0]  root_x;
    logic signed [XY_W-1:0]  zz;
    tas_pkg::cordic_t        prep_next;
    logic                    prep_valid_reg;
    tas_pkg::cordic_t        prep_reg;
    logic signed [SAMPLE_W-1:0] root_z;

    assign root_z = sr_data[ROOT_W].z;
    assign root_x = {{(XY_W - ROOT_W){1'b0}}, sr_data[ROOT_W].root[ROOT_W-1:0]};
    assign zz     = {{(XY_W - SAMPLE_W - 8){root_z[SAMPLE_W-1]}}, root_z, 8'b0};

    always_comb begin
        prep_next.invalid = sr_data[ROOT_W].invalid;
        if (root_z[SAMPLE_W-1]) begin
            prep_next.x   = root_x;
            prep_next.y   = -zz;
            prep_next.acc = ACC_W'(90 << tas_pkg::ACC_FRAC);
        end else begin
            prep_next.x   = zz;
            prep_next.y   = root_x;
            prep_next.acc = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_valid_reg <= 1'b0;
        end else if (en) begin
            prep_valid_reg <= sr_valid[ROOT_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prep_reg <= prep_next;
        end
    end

    // cordic chain, one micro-rotation per cell
    tas_pkg::cordic_t cd_data  [CORDIC_STEPS+1];
    logic             cd_valid [CORDIC_STEPS+1];

    assign cd_valid[0] = prep_valid_reg;
    assign cd_data[0]  = prep_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        tas_cordic_cell #(
            .STAGE (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (cd_valid[i]),
            .in_data   (cd_data[i]),
            .out_valid (cd_valid[i+1]),
            .out_data  (cd_data[i+1])
        );
    end

    // angle finishing and servo level
    tas_servo #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_servo (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (cd_valid[CORDIC_STEPS]),
        .in_data     (cd_data[CORDIC_STEPS]),
        .pwm_period  (pwm_period_reg),
        .angle_limit (angle_limit_reg),
        .out_valid   (res_valid),
        .out_data    (res_data)
    );

    // output register, refilled in the cycle its request is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en && res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && res_valid) begin
            out_reg <= res_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.level, out_reg.tilt};
    assign m_tuser  = {out_reg.invalid, out_reg.over};

`ifndef SYNTHESIS
    // a zero vector reports angle zero, hence never over the limit
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> (m_tdata[15:0] == 16'd0) && !m_tuser[0])
        else $error("zero vector result with non-zero angle or limit flag");

    // tilt never beyond half a turn
    a_tilt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:0] <= 16'(TILT_MAX)))
        else $error("tilt angle above 180 degrees");

    // input is held back only by a result waiting downstream
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a waiting result");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");
`endif

endmodule
